// File: rtl/hsfd_pkg.sv
package hsfd_pkg;

    // Frame layout
    localparam int unsigned FrameBytes = 6;

    // Byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Checksum: CRC-8, MSB first, no reflection, no final xor
    localparam logic [7:0] CrcPoly = 8'h31;
    localparam logic [7:0] CrcInit = 8'hFF;

    // Conversion constants
    localparam logic [14:0] TempScale  = 15'd17500;
    localparam logic [13:0] HumScale   = 14'd12500;
    localparam logic [15:0] FullScale  = 16'd65535;
    localparam logic [15:0] TempOffset = 16'd4500;
    localparam logic [13:0] HumOffset  = 14'd600;
    localparam logic [13:0] HumMax     = 14'd10000;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_CRC_ERR = 1'b1;

    // One decoded frame, handed from front to back
    typedef struct packed {
        logic        bad;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
    } frame_rec_t;

    // Advance the CRC by one byte, eight bit steps unrolled
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/hsfd_if.sv
interface hsfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface hsfd_out_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [14:0] temperature_centi_c;
    logic [13:0]        humidity_centi_pct;

    modport source (output valid, output status, output temperature_centi_c,
                    output humidity_centi_pct, input ready);
    modport sink (input valid, input status, input temperature_centi_c,
                  input humidity_centi_pct, output ready);
endinterface

// File: rtl/humidity_sensor_frame_decoder.sv
// Channel   Dir  Payload                                               Handshake
// rx        in   rx_byte[7:0], frame_start                             valid/ready
// result    out  status, temperature_centi_c[14:0] s, humidity[13:0]   valid/ready
//
// Takes one byte per cycle unless the queue is full; the front updates the CRC per byte.
// After the sixth byte a result goes through the queue, multiply stage and output register.
// The queue holds two frames; rx.ready drops only while it is full.
// Reset is asynchronous, active low, and clears position, CRC and all valid flags.
module humidity_sensor_frame_decoder
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsfd_in_if.sink    rx,
    hsfd_out_if.source result
);

    logic       push;
    frame_rec_t push_rec;
    logic       q_full;
    logic       q_valid;
    frame_rec_t q_head;
    logic       pop;

    // Accept bytes and check the frame
    hsfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    // Decouple front and back
    hsfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    // Convert raw words
    hsfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .pop      (pop),
        .result   (result)
    );

endmodule

// File: rtl/hsfd_front.sv
module hsfd_front
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hsfd_in_if.sink    rx,
    input  logic       q_full,
    output logic       push,
    output frame_rec_t push_rec
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        fail_reg, fail_next;
    logic [15:0] word_t_reg, word_t_next;
    logic [7:0]  h_hi_reg, h_hi_next;
    logic [7:0]  h_lo_reg, h_lo_next;

    logic        accept;
    logic        restart;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_eff;
    logic        fail_eff;
    logic [7:0]  crc_upd;

    // Accept a byte whenever the queue has room for a frame
    assign rx.ready = !q_full;
    assign accept   = rx.valid && rx.ready;

    // Restart on frame_start or on an out-of-range position
    assign restart  = rx.frame_start || (pos_reg >= 3'(FrameBytes));
    assign pos_eff  = restart ? POS_T_HI : pos_reg;
    assign crc_eff  = restart ? CrcInit : crc_reg;
    assign fail_eff = restart ? 1'b0 : fail_reg;
    assign crc_upd  = crc8_update(crc_eff, rx.rx_byte);

    // Classify the byte by its position
    always_comb
    begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        fail_next   = fail_reg;
        word_t_next = word_t_reg;
        h_hi_next   = h_hi_reg;
        push        = 1'b0;
        push_rec.bad   = fail_eff || (crc_eff != rx.rx_byte);
        push_rec.raw_t = word_t_reg;
        push_rec.raw_h = {h_hi_reg, h_lo_reg};
        if (accept)
        begin
            case (pos_eff)
                POS_T_HI:
                begin
                    word_t_next = {rx.rx_byte, word_t_reg[7:0]};
                    crc_next    = crc_upd;
                    fail_next   = fail_eff;
                    pos_next    = POS_T_LO;
                end
                POS_T_LO:
                begin
                    word_t_next = {word_t_reg[15:8], rx.rx_byte};
                    crc_next    = crc_upd;
                    fail_next   = fail_eff;
                    pos_next    = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    fail_next = (crc_eff != rx.rx_byte);
                    crc_next  = CrcInit;
                    pos_next  = POS_H_HI;
                end
                POS_H_HI:
                begin
                    h_hi_next = rx.rx_byte;
                    crc_next  = crc_upd;
                    fail_next = fail_eff;
                    pos_next  = POS_H_LO;
                end
                POS_H_LO:
                begin
                    h_hi_next = h_hi_reg;
                    crc_next  = crc_upd;
                    fail_next = fail_eff;
                    pos_next  = POS_H_CRC;
                end
                default:
                begin
                    push      = 1'b1;
                    crc_next  = CrcInit;
                    fail_next = 1'b0;
                    pos_next  = POS_T_HI;
                end
            endcase
        end
    end

    // Hold the humidity low byte for the final push
    always_comb
    begin
        h_lo_next = h_lo_reg;
        if (accept && (pos_eff == POS_H_LO))
        begin
            h_lo_next = rx.rx_byte;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_T_HI;
            crc_reg  <= CrcInit;
            fail_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            fail_reg <= fail_next;
        end
    end

    // Word bytes
    always_ff @(posedge clk)
    begin
        word_t_reg <= word_t_next;
        h_hi_reg   <= h_hi_next;
        h_lo_reg   <= h_lo_next;
    end

endmodule

// File: rtl/hsfd_queue.sv
module hsfd_queue
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output logic       full,
    output logic       valid,
    output frame_rec_t head
);

    frame_rec_t  mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// File: rtl/hsfd_back.sv
module hsfd_back
    import hsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  frame_rec_t q_head,
    output logic       pop,
    hsfd_out_if.source result
);

    // Stage 1: scaled products
    logic        s1_valid_reg;
    logic        s1_bad_reg;
    logic [30:0] s1_prod_t_reg;
    logic [29:0] s1_prod_h_reg;

    // Output register
    logic               out_valid_reg;
    logic               out_status_reg;
    logic signed [14:0] out_temp_reg, out_temp_next;
    logic [13:0]        out_hum_reg, out_hum_next;

    logic        out_adv;
    logic        s1_take;

    // Quotients by 65535
    logic [14:0] qt0;
    logic [16:0] rt;
    logic [14:0] qt;
    logic [13:0] qh0;
    logic [16:0] rh;
    logic [13:0] qh;
    logic signed [15:0] temp_wide;

    assign out_adv = !out_valid_reg || result.ready;
    assign s1_take = !s1_valid_reg || out_adv;
    assign pop     = q_valid && s1_take;

    // Divide by 65535: high half, then one correction
    always_comb
    begin
        qt0 = s1_prod_t_reg[30:16];
        rt  = {1'b0, s1_prod_t_reg[15:0]} + {2'b00, qt0};
        qt  = qt0 + ((rt >= {1'b0, FullScale}) ? 15'd1 : 15'd0);
        qh0 = s1_prod_h_reg[29:16];
        rh  = {1'b0, s1_prod_h_reg[15:0]} + {3'b000, qh0};
        qh  = qh0 + ((rh >= {1'b0, FullScale}) ? 14'd1 : 14'd0);
    end

    // Offset, clamp and zero on checksum error
    always_comb
    begin
        temp_wide = $signed({1'b0, qt}) - $signed(TempOffset);
        if (s1_bad_reg)
        begin
            out_temp_next = '0;
            out_hum_next  = '0;
        end
        else
        begin
            out_temp_next = $signed(temp_wide[14:0]);
            if (qh < HumOffset)
            begin
                out_hum_next = '0;
            end
            else if (qh > (HumMax + HumOffset))
            begin
                out_hum_next = HumMax;
            end
            else
            begin
                out_hum_next = qh - HumOffset;
            end
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_take)
            begin
                s1_valid_reg <= q_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_bad_reg    <= q_head.bad;
            s1_prod_t_reg <= TempScale * q_head.raw_t;
            s1_prod_h_reg <= HumScale * q_head.raw_h;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_status_reg <= s1_bad_reg ? STATUS_CRC_ERR : STATUS_OK;
            out_temp_reg   <= out_temp_next;
            out_hum_reg    <= out_hum_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.status              = out_status_reg;
    assign result.temperature_centi_c = out_temp_reg;
    assign result.humidity_centi_pct  = out_hum_reg;

endmodule

// File: sim/hsfd_frame_checker.sv
`timescale 1ns / 1ps

module hsfd_frame_checker
    import hsfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hsfd_in_if   rx,
    hsfd_out_if  result,
    output int   failures,
    output int   pending
);

    typedef struct packed {
        logic               status;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } reading_t;

    // Shadow copy of the frame assembly state
    logic [2:0]  frame_pos;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic [7:0]  crc_acc;
    logic        temp_crc_bad;

    // Readings owed by the block, oldest first
    reading_t readings_due[$];

    // Shift one byte through the CRC, bit by bit, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = c[7] ^ b[i];
            c = {c[6:0], 1'b0};
            if (fb)
            begin
                c = c ^ CrcPoly;
            end
        end
        return c;
    endfunction

    // Checksum of a whole 16-bit word, high byte first
    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(CrcInit, w[15:8]), w[7:0]);
    endfunction

    // Convert raw words into centi-degrees and clamped centi-percent
    function automatic reading_t scale_words(input logic [15:0] tw, input logic [15:0] hw);
        int unsigned tq;
        int unsigned hq;
        int          tc;
        int          hc;
        reading_t    r;
        tq = (32'(TempScale) * 32'(tw)) / 32'(FullScale);
        hq = (32'(HumScale) * 32'(hw)) / 32'(FullScale);
        tc = int'(tq) - int'(TempOffset);
        hc = int'(hq) - int'(HumOffset);
        if (hc < 0)
        begin
            hc = 0;
        end
        if (hc > int'(HumMax))
        begin
            hc = int'(HumMax);
        end
        r.status = STATUS_OK;
        r.temp   = tc[14:0];
        r.hum    = hc[13:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            frame_pos    = POS_T_HI;
            temp_word    = '0;
            hum_word     = '0;
            crc_acc      = CrcInit;
            temp_crc_bad = 1'b0;
            failures     = 0;
            readings_due.delete();
            pending     <= 0;
        end
        else
        begin
            // Compare the outgoing transfer against the oldest reading due
            if (result.valid && result.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    $error("result transfer with no reading due: status %0d temp %0d hum %0d",
                           result.status, result.temperature_centi_c, result.humidity_centi_pct);
                    failures++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        failures++;
                    end
                    if (result.temperature_centi_c !== want.temp)
                    begin
                        $error("temperature_centi_c: expected %0d, got %0d",
                               $signed(want.temp), $signed(result.temperature_centi_c));
                        failures++;
                    end
                    if (result.humidity_centi_pct !== want.hum)
                    begin
                        $error("humidity_centi_pct: expected %0d, got %0d",
                               want.hum, result.humidity_centi_pct);
                        failures++;
                    end
                end
            end

            // Advance the shadow state on each incoming transfer
            if (rx.valid && rx.ready)
            begin
                // drop a partial frame on frame_start, and fold stray positions to zero
                if (rx.frame_start || frame_pos >= FrameBytes)
                begin
                    frame_pos    = POS_T_HI;
                    crc_acc      = CrcInit;
                    temp_crc_bad = 1'b0;
                end
                case (frame_pos)
                    POS_T_HI:
                    begin
                        temp_word[15:8] = rx.rx_byte;
                        crc_acc = crc8_step(crc_acc, rx.rx_byte);
                        frame_pos = POS_T_LO;
                    end
                    POS_T_LO:
                    begin
                        temp_word[7:0] = rx.rx_byte;
                        crc_acc = crc8_step(crc_acc, rx.rx_byte);
                        frame_pos = POS_T_CRC;
                    end
                    POS_T_CRC:
                    begin
                        temp_crc_bad = (crc_acc != rx.rx_byte);
                        crc_acc = CrcInit;
                        frame_pos = POS_H_HI;
                    end
                    POS_H_HI:
                    begin
                        hum_word[15:8] = rx.rx_byte;
                        crc_acc = crc8_step(crc_acc, rx.rx_byte);
                        frame_pos = POS_H_LO;
                    end
                    POS_H_LO:
                    begin
                        hum_word[7:0] = rx.rx_byte;
                        crc_acc = crc8_step(crc_acc, rx.rx_byte);
                        frame_pos = POS_H_CRC;
                    end
                    default:
                    begin
                        // sixth byte: zero readings on any checksum mismatch
                        if (temp_crc_bad || crc_acc != rx.rx_byte)
                        begin
                            want.status = STATUS_CRC_ERR;
                            want.temp   = '0;
                            want.hum    = '0;
                        end
                        else
                        begin
                            want = scale_words(temp_word, hum_word);
                        end
                        readings_due.push_back(want);
                        frame_pos    = POS_T_HI;
                        crc_acc      = CrcInit;
                        temp_crc_bad = 1'b0;
                    end
                endcase
            end
            pending <= readings_due.size();
        end
    end

endmodule

// File: sim/humidity_sensor_frame_decoder_tb.sv
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder_tb;
    import hsfd_pkg::*;

    localparam int CycleLimit    = 400000;
    localparam int ItemsPerPhase = 490;
    localparam int LongHold      = 200;
    localparam int SettleCycles  = 20;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   cycle_count;
    int   bytes_sent;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_request;
    bit   in_sync;

    hsfd_in_if  rx_ch ();
    hsfd_out_if res_ch ();

    humidity_sensor_frame_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    hsfd_frame_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx_ch),
        .result   (res_ch),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Drive result ready: random stalls, or a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = LongHold;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic s);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_start <= s;
        @(posedge clk);
        while (!rx_ch.ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Send the first nbytes of a frame; flips corrupt the checksums
    task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input logic s,
                              input logic [7:0] t_flip, input logic [7:0] h_flip,
                              input int nbytes);
        logic [7:0] fb [6];
        fb = '{tw[15:8], tw[7:0], chk.word_crc(tw) ^ t_flip,
               hw[15:8], hw[7:0], chk.word_crc(hw) ^ h_flip};
        for (int i = 0; i < nbytes; i++)
        begin
            send_byte(fb[i], (i == 0) ? s : 1'b0);
        end
        in_sync = (nbytes == FrameBytes);
    endtask

    // Mostly random words, with extremes and clamp edges mixed in
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'd3145 + 16'($urandom_range(0, 2));
            3:       return 16'd55573 + 16'($urandom_range(0, 2));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_flip();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    endfunction

    // Mostly well-formed frames, some cut short, some loose noise bytes
    task automatic random_traffic(input int count);
        int goal;
        int kind;
        int n;
        goal = bytes_sent + count;
        while (bytes_sent < goal)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                send_frame(pick_word(), pick_word(),
                           in_sync ? 1'($urandom_range(0, 1)) : 1'b1,
                           pick_flip(), pick_flip(), FrameBytes);
            end
            else if (kind < 90)
            begin
                send_frame(pick_word(), pick_word(), 1'b1, 8'h00, 8'h00,
                           $urandom_range(1, FrameBytes - 1));
            end
            else
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
                end
                in_sync = 1'b0;
            end
        end
    endtask

    // Stop offering and wait for every reading due
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int sender_gap [3];
        int recv_gap [3];
        sender_gap = '{76, 0, 10};
        recv_gap   = '{0, 76, 10};
        rst_n              = 1'b0;
        rx_ch.valid       <= 1'b0;
        rx_ch.rx_byte     <= 8'h00;
        rx_ch.frame_start <= 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_request       = 1'b0;
        bytes_sent         = 0;
        in_sync            = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: zero words, full-scale words with no frame_start,
        // a bad first checksum, a dropped partial frame, a bad second checksum
        send_frame(16'h0000, 16'h0000, 1'b1, 8'h00, 8'h00, FrameBytes);
        send_frame(16'hFFFF, 16'hFFFF, 1'b0, 8'h00, 8'h00, FrameBytes);
        send_frame(16'h6666, 16'h8000, 1'b1, 8'h01, 8'h00, FrameBytes);
        send_frame(16'h1234, 16'hABCD, 1'b1, 8'h00, 8'h00, 2);
        send_frame(16'h5A5A, 16'hA5A5, 1'b1, 8'h00, 8'h80, FrameBytes);
        drain();

        // Hold off the receiver while the sender keeps pushing
        hold_request = 1'b1;
        random_traffic(ItemsPerPhase - 26);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct  = sender_gap[p];
            recv_stall_pct = recv_gap[p];
            random_traffic(ItemsPerPhase);
            drain();
        end

        repeat (SettleCycles) @(posedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
